// ===== sv/ppmdec_pkg.sv =====
// Shared types and constants for the PPM frame decoder.
// No dependencies; used by every module of the decoder.
package ppmdec_pkg;

	localparam int WIDTH_W        = 16;  // channel width in ticks
	localparam int TIME_W         = 32;  // capture counter
	localparam int NUM_OUT_FIELDS = 8;   // channel fields in one result beat
	localparam int CHAN_IDX_W     = 4;   // holds any channel index up to 16 channels

	localparam logic [TIME_W-1:0]  TIME_ZERO       = '0;
	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 16'd990;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 16'd2010;

	// configuration register indexes
	localparam logic CFG_MIN_WIDTH = 1'b0;
	localparam logic CFG_MAX_WIDTH = 1'b1;

	// one stored channel, passed from the classifier to the frame builder
	typedef struct packed {
		logic                  last;  // completes the frame
		logic [CHAN_IDX_W-1:0] idx;
		logic [WIDTH_W-1:0]    width;
	} entry_t;

endpackage

// ===== sv/ppm_frame_decoder.sv =====
// Top level of the PPM frame decoder: classifier, entry queue and frame builder.
// Depends on ppmdec_pkg, ppmdec_front, ppmdec_fifo and ppmdec_back.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata: capture_time[31:0]
//  m_       out  m_tvalid/m_tready    m_tdata: chan0_width..chan7_width, 16 bit each
//  cfg_     in   cfg_valid/cfg_ready  cfg_index (0 min_width, 1 max_width), cfg_data
//
// One capture beat per cycle while s_tready is high; subtract and compare take the accept cycle.
// A frame beat is registered at the edge that pops its closing channel from the
// queue; that channel is pushed into the queue when its capture beat is accepted.
// A stalled output only holds back the closing channel; the two-entry queue
// takes one more channel behind it, after which s_tready drops.
// Reset is asynchronous: sync is lost, the previous capture is taken as zero.
module ppm_frame_decoder #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,    // capture_time
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,    // chan0_width, chan1_width, .. chan7_width
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);

	logic               push, fifo_full, pop, avail;
	ppmdec_pkg::entry_t push_entry, head;

	ppmdec_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_entry (push_entry),
		.fifo_full  (fifo_full)
	);

	ppmdec_fifo #(.DEPTH(2)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (fifo_full),
		.pop        (pop),
		.avail      (avail),
		.head       (head)
	);

	ppmdec_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.avail    (avail),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== sv/ppmdec_front.sv =====
// Edge classifier: forms intervals between captures, tracks sync and channel count.
// Depends on ppmdec_pkg; feeds ppmdec_fifo.
module ppmdec_front #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [ppmdec_pkg::TIME_W-1:0]         s_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_index,
	input  logic [ppmdec_pkg::WIDTH_W-1:0]        cfg_data,
	output logic                                  push,
	output ppmdec_pkg::entry_t                    push_entry,
	input  logic                                  fifo_full
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

	logic [ppmdec_pkg::WIDTH_W-1:0] min_width_q, max_width_q;
	logic [ppmdec_pkg::TIME_W-1:0]  prev_time_q;
	logic                           sync_q;
	logic [IDX_W-1:0]               chan_q;

	logic                           fire;
	logic [ppmdec_pkg::TIME_W-1:0]  interval;
	logic                           ge_max, gt_max, lt_min, last;

	assign cfg_ready = 1'b1;
	assign s_tready  = !fifo_full;
	assign fire      = s_tvalid && s_tready;

	// wrapping difference handles counter rollover
	assign interval = s_tdata - prev_time_q;
	assign ge_max   = interval >= {16'd0, max_width_q};
	assign gt_max   = interval >  {16'd0, max_width_q};
	assign lt_min   = interval <  {16'd0, min_width_q};
	assign last     = chan_q == LAST_IDX;

	assign push = fire && sync_q && !gt_max && !lt_min;
	assign push_entry.last  = last;
	assign push_entry.idx   = ppmdec_pkg::CHAN_IDX_W'(chan_q);
	assign push_entry.width = interval[ppmdec_pkg::WIDTH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_width_q <= ppmdec_pkg::MIN_WIDTH_RESET;
			max_width_q <= ppmdec_pkg::MAX_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ppmdec_pkg::CFG_MIN_WIDTH: min_width_q <= cfg_data;
				ppmdec_pkg::CFG_MAX_WIDTH: max_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= ppmdec_pkg::TIME_ZERO;
			sync_q      <= 1'b0;
			chan_q      <= '0;
		end else if (fire) begin
			prev_time_q <= s_tdata;
			if (!sync_q) begin
				if (ge_max) begin
					sync_q <= 1'b1;
					chan_q <= '0;
				end
			end else if (gt_max) begin
				chan_q <= '0;
			end else if (lt_min) begin
				sync_q <= 1'b0;
			end else begin
				chan_q <= last ? '0 : chan_q + 1'b1;
			end
		end
	end

	// a channel is only ever queued while synced
	a_push_synced: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> sync_q)
		else $error("channel queued while not synced");

	// first channel after a sync gap always lands in slot zero
	a_sync_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sync_q) |-> chan_q == '0)
		else $error("frame did not start at channel zero");

endmodule

// ===== sv/ppmdec_fifo.sv =====
// Short queue of channel entries between the classifier and the frame builder.
// Depends on ppmdec_pkg for the entry type.
module ppmdec_fifo #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ppmdec_pkg::entry_t push_entry,
	output logic               full,
	input  logic               pop,
	output logic               avail,
	output ppmdec_pkg::entry_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	ppmdec_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign avail   = count_q != '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue, entry lost");

endmodule

// ===== sv/ppmdec_back.sv =====
// Frame builder: writes queued channels into the channel store and emits full frames.
// Depends on ppmdec_pkg; drains ppmdec_fifo.
module ppmdec_back #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  avail,
	input  ppmdec_pkg::entry_t    head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ppmdec_pkg::NUM_OUT_FIELDS*ppmdec_pkg::WIDTH_W-1:0] m_tdata
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [ppmdec_pkg::WIDTH_W-1:0] store_q [NUM_CHANNELS];
	logic [ppmdec_pkg::NUM_OUT_FIELDS-1:0][ppmdec_pkg::WIDTH_W-1:0] frame, out_q;
	logic valid_q;

	// only the closing channel has to wait for the output register
	assign pop      = avail && !(head.last && valid_q && !m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = out_q;

	// closing channel bypasses the store so the frame goes out in one step
	for (genvar j = 0; j < ppmdec_pkg::NUM_OUT_FIELDS; j++) begin : g_field
		if (j < NUM_CHANNELS) begin : g_live
			assign frame[j] = (head.idx == ppmdec_pkg::CHAN_IDX_W'(j)) ?
				head.width : store_q[j];
		end else begin : g_pad
			assign frame[j] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			store_q[head.idx[IDX_W-1:0]] <= head.width;
		end
		if (pop && head.last) begin
			out_q <= frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && head.last) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	a_no_frame_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |-> !(valid_q && !m_tready))
		else $error("pending frame overwritten");

	a_frame_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |=> valid_q)
		else $error("closing channel did not raise a frame");

endmodule

// ===== bench/tb.sv =====
// Testbench for ppm_frame_decoder: capture beats in, frame beats out, checked
// against an in-bench frame predictor. Needs ppmdec_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb;

	localparam int CHANNELS = 8;
	localparam int FRAME_W  = ppmdec_pkg::NUM_OUT_FIELDS * ppmdec_pkg::WIDTH_W;

	// Predicts frame beats from accepted captures and checks the decoder output.
	class frame_board;
		logic [ppmdec_pkg::TIME_W-1:0]  last_capture;
		bit                             synced;
		int unsigned                    chan_count;
		logic [ppmdec_pkg::WIDTH_W-1:0] widths [CHANNELS];
		logic [ppmdec_pkg::WIDTH_W-1:0] min_w;
		logic [ppmdec_pkg::WIDTH_W-1:0] max_w;
		logic [FRAME_W-1:0]             frames_due [$];
		int                             mismatches;
		int                             frames_seen;
		int                             captures;

		function new();
			last_capture = ppmdec_pkg::TIME_ZERO;
			synced       = 1'b0;
			chan_count   = 0;
			min_w        = ppmdec_pkg::MIN_WIDTH_RESET;
			max_w        = ppmdec_pkg::MAX_WIDTH_RESET;
			mismatches   = 0;
			frames_seen  = 0;
			captures     = 0;
		endfunction

		function void set_reg(logic idx, logic [ppmdec_pkg::WIDTH_W-1:0] value);
			if (idx == ppmdec_pkg::CFG_MIN_WIDTH)
				min_w = value;
			else
				max_w = value;
		endfunction

		function int pending();
			return frames_due.size();
		endfunction

		function void note_capture(logic [ppmdec_pkg::TIME_W-1:0] now);
			logic [ppmdec_pkg::TIME_W-1:0] span;
			logic [FRAME_W-1:0]            frame;
			span = now - last_capture;  // wraps mod 2^32
			last_capture = now;
			captures++;
			if (!synced) begin
				if (span >= {16'b0, max_w}) begin
					synced     = 1'b1;
					chan_count = 0;
				end
				return;
			end
			if (span > {16'b0, max_w}) begin
				chan_count = 0;
				return;
			end
			if (span < {16'b0, min_w}) begin
				synced = 1'b0;
				return;
			end
			widths[chan_count] = span[ppmdec_pkg::WIDTH_W-1:0];
			chan_count++;
			if (chan_count < CHANNELS)
				return;
			chan_count = 0;
			frame = '0;
			for (int j = 0; j < CHANNELS && j < ppmdec_pkg::NUM_OUT_FIELDS; j++)
				frame[j*ppmdec_pkg::WIDTH_W +: ppmdec_pkg::WIDTH_W] = widths[j];
			frames_due.push_back(frame);
		endfunction

		function void check_frame(logic [FRAME_W-1:0] got);
			logic [FRAME_W-1:0] want;
			if (frames_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected frame beat: %h", got);
				return;
			end
			want = frames_due.pop_front();
			for (int j = 0; j < ppmdec_pkg::NUM_OUT_FIELDS; j++) begin
				if (got[j*ppmdec_pkg::WIDTH_W +: ppmdec_pkg::WIDTH_W] !==
					want[j*ppmdec_pkg::WIDTH_W +: ppmdec_pkg::WIDTH_W]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("frame %0d chan%0d_width: expected %0d, got %0d",
							frames_seen, j,
							want[j*ppmdec_pkg::WIDTH_W +: ppmdec_pkg::WIDTH_W],
							got[j*ppmdec_pkg::WIDTH_W +: ppmdec_pkg::WIDTH_W]);
				end
			end
			frames_seen++;
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [31:0]        s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [FRAME_W-1:0] m_tdata;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = ppmdec_pkg::CFG_MIN_WIDTH;
	logic [15:0]        cfg_data = '0;

	frame_board                    board;
	logic [ppmdec_pkg::TIME_W-1:0] clock_now = ppmdec_pkg::TIME_ZERO;
	int unsigned                   cur_min = 32'(ppmdec_pkg::MIN_WIDTH_RESET);
	int unsigned                   cur_max = 32'(ppmdec_pkg::MAX_WIDTH_RESET);
	int unsigned                   sent = 0;
	bit                            quiet = 1'b0;     // no idle cycles on either side
	bit                            hold_req = 1'b0;  // receiver holds off for a long stretch

	ppm_frame_decoder #(.NUM_CHANNELS(CHANNELS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_capture(logic [ppmdec_pkg::TIME_W-1:0] t);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		do @(posedge clk); while (!s_tready);
		board.note_capture(t);
		sent++;
	endtask

	task automatic advance(int unsigned span);
		clock_now = clock_now + span;
		send_capture(clock_now);
	endtask

	task automatic send_abs(logic [ppmdec_pkg::TIME_W-1:0] t);
		clock_now = t;
		send_capture(t);
	endtask

	// stop offering captures until every pending frame has come out
	task automatic sender_pause();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		sender_pause();
		repeat (8) @(posedge clk);  // let a closing channel clear the queue
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_reg(idx, value);
		if (idx == ppmdec_pkg::CFG_MIN_WIDTH)
			cur_min = 32'(value);
		else
			cur_max = 32'(value);
	endtask

	function automatic int unsigned sync_gap();
		case ($urandom_range(0, 3))
			0: return cur_max;
			3: return $urandom() | 32'h0001_0000;
			default: return cur_max + $urandom_range(1, 4000);
		endcase
	endfunction

	function automatic int unsigned chan_span();
		if (cur_min > cur_max)
			return cur_min;
		case ($urandom_range(0, 9))
			0: return cur_min;
			1: return cur_max;
			default: return $urandom_range(cur_min, cur_max);
		endcase
	endfunction

	function automatic int unsigned short_span();
		if (cur_min == 0)
			return 0;
		return $urandom_range(0, cur_min - 1);
	endfunction

	// sync gap and a full frame, now and then spoiled by a stray interval
	task automatic send_frame();
		int unsigned r;
		advance(sync_gap());
		repeat (CHANNELS) begin
			r = $urandom_range(0, 39);
			if (r == 0)
				advance(short_span());
			else if (r == 1)
				advance(sync_gap());
			else if (r == 2)
				send_abs($urandom());
			else
				advance(chan_span());
		end
	endtask

	task automatic run_phase(int unsigned lo, int unsigned hi, int unsigned n, bit stress);
		int unsigned start;
		int unsigned kind;
		bit          stressed;
		stressed = 1'b0;
		write_reg(ppmdec_pkg::CFG_MIN_WIDTH, lo[15:0]);
		write_reg(ppmdec_pkg::CFG_MAX_WIDTH, hi[15:0]);
		start = sent;
		while (sent - start < n) begin
			if (stress && !stressed && sent - start >= n / 3) begin
				stressed = 1'b1;
				quiet    = 1'b1;
				hold_req = 1'b1;
			end
			if (stressed && quiet && sent - start >= n / 3 + 80) begin
				quiet = 1'b0;
				sender_pause();
			end
			kind = $urandom_range(0, 99);
			if (kind < 80) begin
				send_frame();
			end else if (kind < 90) begin
				send_abs($urandom());
			end else begin
				advance(sync_gap());
				repeat ($urandom_range(0, CHANNELS - 1)) advance(chan_span());
				advance(short_span());
			end
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				stall    = 300;
				hold_req = 1'b0;
			end else begin
				stall = quiet ? 0 : $urandom_range(0, 14);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			board.check_frame(m_tdata);
		end
	end

	initial begin
		int unsigned lo;
		int unsigned hi;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first edge measured from zero; equal to max syncs; min and max channels
		advance(2010);
		advance(990);
		advance(2010);
		repeat (6) advance(1500);
		// long jump restarts the frame, then channels across the counter wrap
		send_abs(32'hFFFF_FFFF);
		repeat (8) advance(1000);
		// short interval drops sync, below max stays out, above max resyncs
		advance(500);
		advance(1999);
		advance(2011);
		repeat (3) advance(1200);
		advance(3000);

		run_phase(1000, 2000, 200, 1'b1);
		run_phase(0, 65535, 150, 1'b0);
		run_phase(65535, 65535, 100, 1'b0);
		run_phase(0, 0, 100, 1'b0);
		run_phase(3000, 1000, 100, 1'b0);  // min above max: no channel is valid
		lo = $urandom_range(0, 65535);
		hi = $urandom_range(0, 65535);
		if (lo > hi && $urandom_range(0, 3) != 0)
			run_phase(hi, lo, 150, 1'b0);
		else
			run_phase(lo, hi, 150, 1'b0);
		run_phase(32'(ppmdec_pkg::MIN_WIDTH_RESET), 32'(ppmdec_pkg::MAX_WIDTH_RESET),
			200, 1'b0);

		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.pending() != 0)
			$display("%0d expected frames never came out", board.pending());

		$display("%0d captures sent, %0d frames compared over seven width settings",
			board.captures, board.frames_seen);
		$display("(reset values, full range, both zero, both max, min above max, random)");
		if (board.mismatches == 0 && board.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/ppmdec_pkg.sv
sv/ppmdec_front.sv
sv/ppmdec_fifo.sv
sv/ppmdec_back.sv
sv/ppm_frame_decoder.sv
bench/tb.sv
